@@ design/rth_pkg.sv @@
package rth_pkg;

    // default geometry of one coordinate
    localparam int COORD_WIDTH_DEF = 20;
    localparam int FRAC_BITS_DEF   = 12;

    // configuration port
    localparam int LIMIT_W   = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGENERATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL   = 2'd1;

    localparam logic [LIMIT_W-1:0] DEGENERATE_RESET = 40'd2814750;
    localparam logic [LIMIT_W-1:0] PARALLEL_RESET   = 40'd6871948;

endpackage

@@ design/rth_mul.sv @@
// Signed multiplier, two register stages: four half-width partial products,
// then their weighted sum.
module rth_mul #(
    parameter int AW = 21,
    parameter int BW = 21
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int KA = AW / 2;
    localparam int KB = BW / 2;
    localparam int HA = AW - KA;
    localparam int HB = BW - KB;
    localparam int PW = AW + BW;

    logic signed [HA-1:0] ah;
    logic signed [KA:0]   al;
    logic signed [HB-1:0] bh;
    logic signed [KB:0]   bl;

    logic signed [HA+HB-1:0] hh_reg;
    logic signed [HA+KB:0]   hl_reg;
    logic signed [KA+HB:0]   lh_reg;
    logic signed [KA+KB+1:0] ll_reg;

    logic signed [PW-1:0] e_hh;
    logic signed [PW-1:0] e_hl;
    logic signed [PW-1:0] e_lh;
    logic signed [PW-1:0] e_ll;
    logic signed [PW-1:0] p_next;
    logic signed [PW-1:0] p_reg;

    // split: high halves signed, low halves as non-negative values
    assign ah = a[AW-1:KA];
    assign al = {1'b0, a[KA-1:0]};
    assign bh = b[BW-1:KB];
    assign bl = {1'b0, b[KB-1:0]};

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= al * bl;
        end
    end

    // weighted sum
    assign e_hh = hh_reg;
    assign e_hl = hl_reg;
    assign e_lh = lh_reg;
    assign e_ll = ll_reg;
    assign p_next = (e_hh <<< (KA + KB)) + (e_hl <<< KA) + (e_lh <<< KB) + e_ll;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ design/rth_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// ovf flags a quotient that does not fit in QW bits.
module rth_div #(
    parameter int NUMW = 79,
    parameter int DENW = 65,
    parameter int QW   = 34
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic [QW-1:0]   quot,
    output logic            ovf
);

    localparam int RW = (NUMW > DENW + QW) ? NUMW + 1 : DENW + QW + 1;

    logic [RW-1:0]   rem_reg [QW-1];
    logic [DENW-1:0] den_reg [QW-1];
    logic [QW-1:0]   q_reg   [QW];
    logic [QW-1:0]   ovf_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0]   rem_cur;
        logic [RW-1:0]   trial;
        logic [DENW-1:0] den_cur;
        logic [QW-1:0]   q_cur;
        logic            ovf_cur;
        logic            ge;

        // stage input: the ports for the first stage, else the previous stage
        if (k == 0) begin : g_first
            assign rem_cur = RW'(num);
            assign den_cur = den;
            assign q_cur   = '0;
            assign ovf_cur = RW'(num) >= (RW'(den) << QW);
        end else begin : g_next
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign q_cur   = q_reg[k-1];
            assign ovf_cur = ovf_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign trial = RW'(den_cur) << (QW - 1 - k);
        assign ge    = rem_cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_cur | (QW'(ge) << (QW - 1 - k));
                ovf_reg[k] <= ovf_cur;
            end
        end

        // the last stage keeps no remainder
        if (k < QW - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_cur - trial : rem_cur;
                    den_reg[k] <= den_cur;
                end
            end
        end
    end

    assign quot = q_reg[QW-1];
    assign ovf  = ovf_reg[QW-1];

endmodule

@@ design/ray_triangle_hit_test_top.sv @@
// Ray / triangle hit test, fully pipelined.
// Item channel: item_valid / item_stall carry one beat of ray_origin, ray_dir,
// vertex_a, vertex_b, vertex_c (each x,y,z packed, x in the low bits).
// Result channel: result_valid / result_stall carry one beat of hit.
// Config channel: cfg_valid / cfg_ready (always ready) writes
// degenerate_limit (index 0) or parallel_limit (index 1); other indexes are
// dropped. Write only while no item is in flight.
// Throughput: one beat per cycle while result_stall does not hold the pipeline;
// the divider producing the plane distance gives one quotient bit per stage and
// makes up most of the pipeline's stages.
// Every stage advances together; when a result waits under result_stall the
// whole pipeline holds and item_stall rises, so nothing is lost or repeated.
// Reset empties the pipeline (no result beats) and loads the default limits.
module ray_triangle_hit_test_top #(
    parameter int COORD_WIDTH = rth_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rth_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [3*COORD_WIDTH-1:0]       ray_origin,
    input  logic [3*COORD_WIDTH-1:0]       ray_dir,
    input  logic [3*COORD_WIDTH-1:0]       vertex_a,
    input  logic [3*COORD_WIDTH-1:0]       vertex_b,
    input  logic [3*COORD_WIDTH-1:0]       vertex_c,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           hit,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rth_pkg::LIMIT_W-1:0]    cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LW   = rth_pkg::LIMIT_W;
    localparam int PV   = 3 * CW;
    localparam int UW   = CW + 1;
    localparam int PU   = 3 * UW;
    localparam int PW1  = 2 * UW;
    localparam int NW   = PW1 + 1;
    localparam int NNW  = 2 * NW + 2;
    localparam int AAW  = NW + UW + 3;
    localparam int BSW  = NW + CW + 2;
    localparam int NUMW = AAW + F;
    localparam int QW   = CW + F + 2;
    localparam int PRW  = QW + 1 + CW;
    localparam int IWD  = PRW + 2;
    localparam int WW   = CW + 3;
    localparam int QSW  = PW1 + 2;
    localparam int WSW  = WW + UW + 2;
    localparam int DW   = 2 * QSW + 1;
    localparam int SW5  = QSW + WSW + 1;
    localparam int FW   = SW5 + 2;
    localparam int TD   = 8 + QW;
    localparam int LAT  = TD + 9;

    localparam logic signed [IWD-1:0] FAR_HI = IWD'(1) << (CW + 1);
    localparam logic signed [IWD-1:0] FAR_LO = -FAR_HI;

    logic en;

    // configuration
    logic [LW-1:0] deg_limit_reg;
    logic [LW-1:0] par_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_limit_reg <= rth_pkg::DEGENERATE_RESET;
            par_limit_reg <= rth_pkg::PARALLEL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rth_pkg::CFG_DEGENERATE: deg_limit_reg <= cfg_data;
                rth_pkg::CFG_PARALLEL:   par_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold everything while the output beat is refused
    logic [LAT-1:0] vld_ln;

    assign en           = !vld_ln[LAT-1] || !result_stall;
    assign item_stall   = !en;
    assign result_valid = vld_ln[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_ln <= '0;
        end
        else if (en)
        begin
            vld_ln <= {vld_ln[LAT-2:0], item_valid};
        end
    end

    // side lines: entry j holds the value at stage j+1
    logic [PV-1:0] o_ln  [TD+2];
    logic [PV-1:0] d_ln  [TD];
    logic [PV-1:0] a_ln  [TD+2];
    logic [PU-1:0] u_ln  [TD+3];
    logic [PU-1:0] v_ln  [TD+3];
    logic [PU-1:0] w0_ln [4];
    logic [QW:0]   rej_ln;

    logic signed [UW-1:0] u_in  [3];
    logic signed [UW-1:0] v_in  [3];
    logic signed [UW-1:0] w0_in [3];

    // stage 1: edge vectors and origin offset
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_in[k]  = $signed(vertex_b[k*CW +: CW]) - $signed(vertex_a[k*CW +: CW]);
            v_in[k]  = $signed(vertex_c[k*CW +: CW]) - $signed(vertex_a[k*CW +: CW]);
            w0_in[k] = $signed(vertex_a[k*CW +: CW]) - $signed(ray_origin[k*CW +: CW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_ln[0]  <= ray_origin;
            d_ln[0]  <= ray_dir;
            a_ln[0]  <= vertex_a;
            u_ln[0]  <= {u_in[2], u_in[1], u_in[0]};
            v_ln[0]  <= {v_in[2], v_in[1], v_in[0]};
            w0_ln[0] <= {w0_in[2], w0_in[1], w0_in[0]};
            for (int j = 1; j < TD + 2; j++)
            begin
                o_ln[j] <= o_ln[j-1];
                a_ln[j] <= a_ln[j-1];
            end
            for (int j = 1; j < TD; j++)
            begin
                d_ln[j] <= d_ln[j-1];
            end
            for (int j = 1; j < TD + 3; j++)
            begin
                u_ln[j] <= u_ln[j-1];
                v_ln[j] <= v_ln[j-1];
            end
            for (int j = 1; j < 4; j++)
            begin
                w0_ln[j] <= w0_ln[j-1];
            end
        end
    end

    // stages 2-3: cross product terms
    logic signed [PW1-1:0] m1a [3];
    logic signed [PW1-1:0] m1b [3];

    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        rth_mul #(.AW(UW), .BW(UW)) u_pa (
            .clk(clk), .en(en),
            .a($signed(u_ln[0][K1*UW +: UW])), .b($signed(v_ln[0][K2*UW +: UW])),
            .p(m1a[k])
        );
        rth_mul #(.AW(UW), .BW(UW)) u_pb (
            .clk(clk), .en(en),
            .a($signed(u_ln[0][K2*UW +: UW])), .b($signed(v_ln[0][K1*UW +: UW])),
            .p(m1b[k])
        );
    end

    // stage 4: normal
    logic signed [NW-1:0] n4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                n4_reg[k] <= m1a[k] - m1b[k];
            end
        end
    end

    // stages 5-6: n.n, n.w0, n.d terms
    logic signed [2*NW-1:0]  m2nn [3];
    logic signed [NW+UW-1:0] m2nw [3];
    logic signed [NW+CW-1:0] m2nd [3];

    for (genvar k = 0; k < 3; k++) begin : g_dots
        rth_mul #(.AW(NW), .BW(NW)) u_nn (
            .clk(clk), .en(en), .a(n4_reg[k]), .b(n4_reg[k]), .p(m2nn[k])
        );
        rth_mul #(.AW(NW), .BW(UW)) u_nw (
            .clk(clk), .en(en), .a(n4_reg[k]), .b($signed(w0_ln[3][k*UW +: UW])),
            .p(m2nw[k])
        );
        rth_mul #(.AW(NW), .BW(CW)) u_nd (
            .clk(clk), .en(en), .a(n4_reg[k]), .b($signed(d_ln[3][k*CW +: CW])),
            .p(m2nd[k])
        );
    end

    // stage 7: dot sums, a = -n.(A-O), b = n.d
    logic signed [NNW-1:0] nn_sum;
    logic signed [AAW-1:0] nw_sum;
    logic signed [BSW-1:0] nd_sum;
    logic [NNW-1:0]        nn7_reg;
    logic signed [AAW-1:0] a7_reg;
    logic signed [BSW-1:0] b7_reg;

    always_comb
    begin
        nn_sum = m2nn[0] + m2nn[1] + m2nn[2];
        nw_sum = m2nw[0] + m2nw[1] + m2nw[2];
        nd_sum = m2nd[0] + m2nd[1] + m2nd[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn7_reg <= nn_sum;
            a7_reg  <= -nw_sum;
            b7_reg  <= nd_sum;
        end
    end

    // stage 8: early rejects and magnitudes for the divider
    logic [AAW-1:0]  abs_a;
    logic [BSW-1:0]  abs_b;
    logic            degen;
    logic            para;
    logic            behind;
    logic [NUMW-1:0] num8_reg;
    logic [BSW-1:0]  den8_reg;

    always_comb
    begin
        abs_a  = a7_reg[AAW-1] ? -a7_reg : a7_reg;
        abs_b  = b7_reg[BSW-1] ? -b7_reg : b7_reg;
        degen  = (NNW + LW)'(nn7_reg) < (NNW + LW)'(deg_limit_reg);
        para   = (b7_reg == '0) || ((BSW + LW)'(abs_b) < (BSW + LW)'(par_limit_reg));
        behind = (a7_reg != '0) && (a7_reg[AAW-1] != b7_reg[BSW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num8_reg <= {abs_a, {F{1'b0}}};
            den8_reg <= abs_b;
            rej_ln   <= {rej_ln[QW-1:0], degen | para | behind};
        end
    end

    // stages 9 .. 8+QW: plane distance r = |a| * 2^F / |b|
    logic [QW-1:0] quot;
    logic          ovf;

    rth_div #(.NUMW(NUMW), .DENW(BSW), .QW(QW)) u_div (
        .clk(clk), .en(en), .num(num8_reg), .den(den8_reg), .quot(quot), .ovf(ovf)
    );

    // two stages: r*d and the edge dot products
    logic signed [PRW-1:0] m3rd [3];
    logic signed [PW1-1:0] m3uu [3];
    logic signed [PW1-1:0] m3vv [3];
    logic signed [PW1-1:0] m3uv [3];
    logic [1:0]            rjm_reg;

    for (genvar k = 0; k < 3; k++) begin : g_point
        rth_mul #(.AW(QW + 1), .BW(CW)) u_rd (
            .clk(clk), .en(en), .a($signed({1'b0, quot})),
            .b($signed(d_ln[TD-1][k*CW +: CW])), .p(m3rd[k])
        );
        rth_mul #(.AW(UW), .BW(UW)) u_uu (
            .clk(clk), .en(en), .a($signed(u_ln[TD-1][k*UW +: UW])),
            .b($signed(u_ln[TD-1][k*UW +: UW])), .p(m3uu[k])
        );
        rth_mul #(.AW(UW), .BW(UW)) u_vv (
            .clk(clk), .en(en), .a($signed(v_ln[TD-1][k*UW +: UW])),
            .b($signed(v_ln[TD-1][k*UW +: UW])), .p(m3vv[k])
        );
        rth_mul #(.AW(UW), .BW(UW)) u_uv (
            .clk(clk), .en(en), .a($signed(u_ln[TD-1][k*UW +: UW])),
            .b($signed(v_ln[TD-1][k*UW +: UW])), .p(m3uv[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rjm_reg <= '0;
        end
        else if (en)
        begin
            rjm_reg <= {rjm_reg[0], rej_ln[QW] | ovf};
        end
    end

    // intersection point, truncated toward zero, and w = I - A
    logic signed [PRW:0]   pe_c  [3];
    logic signed [PRW:0]   t_c   [3];
    logic signed [IWD-1:0] i_c   [3];
    logic signed [WW-1:0]  w_c   [3];
    logic [2:0]            far_c;
    logic signed [WW-1:0]  w_t   [3];
    logic signed [QSW-1:0] uu_t;
    logic signed [QSW-1:0] vv_t;
    logic signed [QSW-1:0] uv_t;
    logic                  rj_t;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pe_c[k]  = m3rd[k] + $signed({{(PRW + 1 - F){1'b0}}, {F{m3rd[k][PRW-1]}}});
            t_c[k]   = pe_c[k] >>> F;
            i_c[k]   = $signed(o_ln[TD+1][k*CW +: CW]) + t_c[k];
            far_c[k] = (i_c[k] >= FAR_HI) || (i_c[k] <= FAR_LO);
            w_c[k]   = $signed(i_c[k][CW+1:0]) - $signed(a_ln[TD+1][k*CW +: CW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w_t[k] <= w_c[k];
            end
            uu_t <= m3uu[0] + m3uu[1] + m3uu[2];
            vv_t <= m3vv[0] + m3vv[1] + m3vv[2];
            uv_t <= m3uv[0] + m3uv[1] + m3uv[2];
            rj_t <= rjm_reg[1] | (|far_c);
        end
    end

    // two stages: w.u, w.v terms and the denominator products
    logic signed [WW+UW-1:0] m4wu [3];
    logic signed [WW+UW-1:0] m4wv [3];
    logic signed [2*QSW-1:0] m4uvuv;
    logic signed [2*QSW-1:0] m4uuvv;
    logic signed [QSW-1:0]   uu_dl [2];
    logic signed [QSW-1:0]   vv_dl [2];
    logic signed [QSW-1:0]   uv_dl [2];
    logic [1:0]              rjw_dl;

    for (genvar k = 0; k < 3; k++) begin : g_bary
        rth_mul #(.AW(WW), .BW(UW)) u_wu (
            .clk(clk), .en(en), .a(w_t[k]), .b($signed(u_ln[TD+2][k*UW +: UW])),
            .p(m4wu[k])
        );
        rth_mul #(.AW(WW), .BW(UW)) u_wv (
            .clk(clk), .en(en), .a(w_t[k]), .b($signed(v_ln[TD+2][k*UW +: UW])),
            .p(m4wv[k])
        );
    end

    rth_mul #(.AW(QSW), .BW(QSW)) u_uvuv (
        .clk(clk), .en(en), .a(uv_t), .b(uv_t), .p(m4uvuv)
    );
    rth_mul #(.AW(QSW), .BW(QSW)) u_uuvv (
        .clk(clk), .en(en), .a(uu_t), .b(vv_t), .p(m4uuvv)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_dl[0] <= uu_t;
            uu_dl[1] <= uu_dl[0];
            vv_dl[0] <= vv_t;
            vv_dl[1] <= vv_dl[0];
            uv_dl[0] <= uv_t;
            uv_dl[1] <= uv_dl[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rjw_dl <= '0;
        end
        else if (en)
        begin
            rjw_dl <= {rjw_dl[0], rj_t};
        end
    end

    // dot sums and D
    logic signed [WSW-1:0] wu_w;
    logic signed [WSW-1:0] wv_w;
    logic signed [DW-1:0]  d_w;
    logic signed [QSW-1:0] uu_w;
    logic signed [QSW-1:0] vv_w;
    logic signed [QSW-1:0] uv_w;
    logic                  rj_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wu_w <= m4wu[0] + m4wu[1] + m4wu[2];
            wv_w <= m4wv[0] + m4wv[1] + m4wv[2];
            d_w  <= m4uvuv - m4uuvv;
            uu_w <= uu_dl[1];
            vv_w <= vv_dl[1];
            uv_w <= uv_dl[1];
            rj_w <= rjw_dl[1];
        end
    end

    // two stages: S and T products
    logic signed [QSW+WSW-1:0] m5a;
    logic signed [QSW+WSW-1:0] m5b;
    logic signed [QSW+WSW-1:0] m5c;
    logic signed [QSW+WSW-1:0] m5d;
    logic signed [DW-1:0]      dd_dl [2];
    logic [1:0]                rjh_dl;

    rth_mul #(.AW(QSW), .BW(WSW)) u_s1 (.clk(clk), .en(en), .a(uv_w), .b(wv_w), .p(m5a));
    rth_mul #(.AW(QSW), .BW(WSW)) u_s2 (.clk(clk), .en(en), .a(vv_w), .b(wu_w), .p(m5b));
    rth_mul #(.AW(QSW), .BW(WSW)) u_t1 (.clk(clk), .en(en), .a(uv_w), .b(wu_w), .p(m5c));
    rth_mul #(.AW(QSW), .BW(WSW)) u_t2 (.clk(clk), .en(en), .a(uu_w), .b(wv_w), .p(m5d));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_dl[0] <= d_w;
            dd_dl[1] <= dd_dl[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rjh_dl <= '0;
        end
        else if (en)
        begin
            rjh_dl <= {rjh_dl[0], rj_w};
        end
    end

    // final stage: sign-normalized barycentric compare
    logic signed [FW-1:0] s_f;
    logic signed [FW-1:0] t_f;
    logic signed [FW-1:0] d_f;
    logic signed [FW-1:0] sn;
    logic signed [FW-1:0] tn;
    logic signed [FW-1:0] dn;
    logic                 hit_next;
    logic                 hit_reg;

    always_comb
    begin
        s_f = m5a - m5b;
        t_f = m5c - m5d;
        d_f = dd_dl[1];
        if (d_f[FW-1])
        begin
            sn = -s_f;
            tn = -t_f;
            dn = -d_f;
        end
        else
        begin
            sn = s_f;
            tn = t_f;
            dn = d_f;
        end
        hit_next = !rjh_dl[1] && (d_f != '0) && !sn[FW-1] && !tn[FW-1]
                   && (sn <= dn) && ((sn + tn) <= dn);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

@@ design/rth_check.sv @@
// Port-level checks for the hit test pipeline.
module rth_check (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic hit,
    input logic cfg_valid,
    input logic cfg_ready
);

    // a refused result beat stays
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(hit))
        else $error("result beat dropped or changed under stall");

    // input stalls only behind a refused result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stall without a refused result");

    // a free output never stalls the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !(result_valid && result_stall) |-> !item_stall)
        else $error("item stalled while output is free");

    // config writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind ray_triangle_hit_test_top rth_check u_rth_check (
    .clk(clk),
    .rst_n(rst_n),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .hit(hit),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
